/* rtl/pdt_pkg.sv */
// ----------------------------------------------------------------------------
// pdt_pkg
// Shared types, field widths and the control store of the deadline timer.
// ----------------------------------------------------------------------------
`default_nettype none

package pdt_pkg;

   // transaction field widths
   localparam int FUNC_W     = 2;
   localparam int ABSOLUTE_W = 1;
   localparam int WHEN_W     = 48;
   localparam int EVERY_W    = 48;
   localparam int DELTA_W    = 16;
   localparam int FIRED_W    = 1;
   localparam int OVR_W      = 32;

   localparam int TIME_BITS_DEF = 48;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SCHED = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_FETCH,
      OP_ADD_TIME,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DIV_DONE,
      OP_FIRE,
      OP_SCHED,
      OP_READ,
      OP_POST
   } op_type;

   // jump conditions
   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NOT_ACCEPT,
      COND_IS_SCHED,
      COND_IS_READ,
      COND_NOT_TICK,
      COND_NOT_BEHIND,
      COND_DIV_MORE,
      COND_OUT_BUSY
   } cond_type;

   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   // program labels
   localparam step_type STEP_FETCH    = 4'd0;
   localparam step_type STEP_DISP_S   = 4'd1;
   localparam step_type STEP_DISP_R   = 4'd2;
   localparam step_type STEP_DISP_X   = 4'd3;
   localparam step_type STEP_TICK     = 4'd4;
   localparam step_type STEP_BEHIND   = 4'd5;
   localparam step_type STEP_DIV_INIT = 4'd6;
   localparam step_type STEP_DIV_LOOP = 4'd7;
   localparam step_type STEP_DIV_DONE = 4'd8;
   localparam step_type STEP_FIRE     = 4'd9;
   localparam step_type STEP_SCHED    = 4'd10;
   localparam step_type STEP_READ     = 4'd11;
   localparam step_type STEP_POST     = 4'd12;
   localparam step_type STEP_WRAP     = 4'd13;

   // control store: jump to target when the condition holds, else fall through
   function automatic ctrl_word_type ucode(step_type s);
      ctrl_word_type w;
      w = '{op: OP_NONE, cond: COND_ALWAYS, target: STEP_FETCH};
      unique case (s)
         STEP_FETCH:    w = '{op: OP_FETCH,    cond: COND_NOT_ACCEPT, target: STEP_FETCH};
         STEP_DISP_S:   w = '{op: OP_NONE,     cond: COND_IS_SCHED,   target: STEP_SCHED};
         STEP_DISP_R:   w = '{op: OP_NONE,     cond: COND_IS_READ,    target: STEP_READ};
         STEP_DISP_X:   w = '{op: OP_NONE,     cond: COND_NOT_TICK,   target: STEP_POST};
         STEP_TICK:     w = '{op: OP_ADD_TIME, cond: COND_NEVER,      target: STEP_FETCH};
         STEP_BEHIND:   w = '{op: OP_NONE,     cond: COND_NOT_BEHIND, target: STEP_FIRE};
         STEP_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_NEVER,      target: STEP_FETCH};
         STEP_DIV_LOOP: w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE,   target: STEP_DIV_LOOP};
         STEP_DIV_DONE: w = '{op: OP_DIV_DONE, cond: COND_NEVER,      target: STEP_FETCH};
         STEP_FIRE:     w = '{op: OP_FIRE,     cond: COND_ALWAYS,     target: STEP_POST};
         STEP_SCHED:    w = '{op: OP_SCHED,    cond: COND_ALWAYS,     target: STEP_POST};
         STEP_READ:     w = '{op: OP_READ,     cond: COND_ALWAYS,     target: STEP_POST};
         STEP_POST:     w = '{op: OP_POST,     cond: COND_OUT_BUSY,   target: STEP_POST};
         STEP_WRAP:     w = '{op: OP_NONE,     cond: COND_ALWAYS,     target: STEP_FETCH};
         default:       w = '{op: OP_NONE,     cond: COND_ALWAYS,     target: STEP_FETCH};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* rtl/pdt_if.sv */
// ----------------------------------------------------------------------------
// pdt_req_if / pdt_rsp_if
// Valid/ready channels for timer requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdt_req_if;
   logic                              valid;
   logic                              ready;
   logic [pdt_pkg::FUNC_W-1:0]        func;
   logic [pdt_pkg::ABSOLUTE_W-1:0]    absolute;
   logic [pdt_pkg::WHEN_W-1:0]        when;
   logic [pdt_pkg::EVERY_W-1:0]       every;
   logic [pdt_pkg::DELTA_W-1:0]       delta;

   modport source (output valid, func, absolute, when, every, delta, input ready);
   modport sink   (input valid, func, absolute, when, every, delta, output ready);
endinterface

interface pdt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pdt_pkg::FIRED_W-1:0]       fired;
   logic [pdt_pkg::OVR_W-1:0]         overruns_read;

   modport source (output valid, fired, overruns_read, input ready);
   modport sink   (input valid, fired, overruns_read, output ready);
endinterface

`default_nettype wire

/* rtl/periodic_deadline_timer_unit.sv */
// ----------------------------------------------------------------------------
// periodic_deadline_timer_unit
// One-shot / periodic deadline timer with saturating overrun count.
// ----------------------------------------------------------------------------
// One request transaction is handled at a time and each yields exactly one
// response transaction. After a request is accepted the sequencer dispatches
// on the function code: a schedule or a read runs its operation, an unused
// code goes straight to the response, and a tick adds delta to the time and,
// when a periodic timer has fallen behind, gets the count of missed periods
// from a restoring divider that retires one quotient bit per cycle, before it
// checks for expiry. Before loading the response the sequencer waits while
// the previous response has not left, and after loading it the sequencer
// returns to fetch. A microcoded sequencer steps through a small control
// store; the response sits in its own output register, so a new request is
// taken while the previous response waits.
`default_nettype none

module periodic_deadline_timer_unit #(
   parameter int TIME_BITS = pdt_pkg::TIME_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pdt_req_if.sink    req_chan,
   pdt_rsp_if.source  rsp_chan
);
   import pdt_pkg::*;

   localparam int CNT_W = $clog2(TIME_BITS + 1);
   localparam int SUM_W = ((TIME_BITS > OVR_W) ? TIME_BITS : OVR_W) + 1;
   localparam logic [TIME_BITS-1:0] TMAX    = {TIME_BITS{1'b1}};
   localparam logic [OVR_W-1:0]     OVR_MAX = {OVR_W{1'b1}};

   // sequencer
   step_type       pc_ff, pc_in;
   ctrl_word_type  cw;
   logic           cond_hit;

   // latched request
   logic [FUNC_W-1:0]    func_ff, func_in;
   logic                 abs_ff, abs_in;
   logic [TIME_BITS-1:0] when_ff, when_in;
   logic [TIME_BITS-1:0] every_ff, every_in;
   logic [DELTA_W-1:0]   delta_ff, delta_in;

   // timer state
   logic [TIME_BITS-1:0] ct_ff, ct_in;    // current time
   logic [TIME_BITS-1:0] dl_ff, dl_in;    // deadline, 0 = disarmed
   logic [TIME_BITS-1:0] per_ff, per_in;  // period, 0 = one-shot
   logic [OVR_W-1:0]     ovr_ff, ovr_in;

   // divider: remainder, dividend shifting out / quotient shifting in
   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [TIME_BITS-1:0] dq_ff, dq_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // pending result and output register
   logic                 res_fired_ff, res_fired_in;
   logic [OVR_W-1:0]     res_ovr_ff, res_ovr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_fired_ff, rsp_fired_in;
   logic [OVR_W-1:0]     rsp_ovr_ff, rsp_ovr_in;

   // datapath helpers
   logic                 accept;
   logic                 out_busy;
   logic [TIME_BITS:0]   time_sum;
   logic [TIME_BITS:0]   rel_sum;
   logic [TIME_BITS:0]   rearm_sum;
   logic [TIME_BITS:0]   rem_sh;
   logic [TIME_BITS:0]   rem_diff;
   logic [SUM_W-1:0]     ovr_sum;
   logic                 behind;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_busy = rsp_valid_ff && !rsp_chan.ready;

   assign req_chan.ready        = (pc_ff == STEP_FETCH);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.fired        = rsp_fired_ff;
   assign rsp_chan.overruns_read = rsp_ovr_ff;

   // saturating adders: carry out means past the top of the time range
   assign time_sum  = {1'b0, ct_ff} + (TIME_BITS + 1)'(delta_ff);
   assign rel_sum   = {1'b0, when_ff} + {1'b0, ct_ff};
   assign rearm_sum = {1'b0, dl_ff} + {1'b0, per_ff};

   // one restoring division step
   assign rem_sh   = {rem_ff, dq_ff[TIME_BITS-1]};
   assign rem_diff = rem_sh - {1'b0, per_ff};

   assign ovr_sum = SUM_W'(dq_ff) + SUM_W'(ovr_ff);

   // armed periodic timer that has passed its deadline
   assign behind = (dl_ff != '0) && (per_ff != '0) && (ct_ff > dl_ff);

   assign cw = ucode(pc_ff);

   always_comb begin
      case (cw.cond)
         COND_NEVER:      cond_hit = 1'b0;
         COND_ALWAYS:     cond_hit = 1'b1;
         COND_NOT_ACCEPT: cond_hit = !accept;
         COND_IS_SCHED:   cond_hit = (func_ff == FUNC_SCHED);
         COND_IS_READ:    cond_hit = (func_ff == FUNC_READ);
         COND_NOT_TICK:   cond_hit = (func_ff != FUNC_TICK);
         COND_NOT_BEHIND: cond_hit = !behind;
         COND_DIV_MORE:   cond_hit = (cnt_ff != CNT_W'(1));
         COND_OUT_BUSY:   cond_hit = out_busy;
         default:         cond_hit = 1'b0;
      endcase
      pc_in = cond_hit ? cw.target : step_type'(pc_ff + 1'b1);
   end

   always_comb begin
      func_in      = func_ff;
      abs_in       = abs_ff;
      when_in      = when_ff;
      every_in     = every_ff;
      delta_in     = delta_ff;
      ct_in        = ct_ff;
      dl_in        = dl_ff;
      per_in       = per_ff;
      ovr_in       = ovr_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      cnt_in       = cnt_ff;
      res_fired_in = res_fired_ff;
      res_ovr_in   = res_ovr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_fired_in = rsp_fired_ff;
      rsp_ovr_in   = rsp_ovr_ff;

      case (cw.op)
         OP_FETCH: begin
            if (accept) begin
               func_in      = req_chan.func;
               abs_in       = req_chan.absolute[0];
               when_in      = TIME_BITS'(req_chan.when);
               every_in     = TIME_BITS'(req_chan.every);
               delta_in     = req_chan.delta;
               res_fired_in = 1'b0;
               res_ovr_in   = '0;
            end
         end
         OP_ADD_TIME: begin
            ct_in = time_sum[TIME_BITS] ? TMAX : time_sum[TIME_BITS-1:0];
         end
         OP_DIV_INIT: begin
            rem_in = '0;
            dq_in  = ct_ff - dl_ff;
            cnt_in = CNT_W'(TIME_BITS);
         end
         OP_DIV_STEP: begin
            if (!rem_diff[TIME_BITS]) begin
               rem_in = rem_diff[TIME_BITS-1:0];
            end else begin
               rem_in = rem_sh[TIME_BITS-1:0];
            end
            dq_in  = {dq_ff[TIME_BITS-2:0], !rem_diff[TIME_BITS]};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         OP_DIV_DONE: begin
            // deadline advanced by whole missed periods = now - remainder
            dl_in = ct_ff - rem_ff;
            if (ovr_sum >= SUM_W'(OVR_MAX)) begin
               ovr_in = OVR_MAX;
            end else begin
               ovr_in = ovr_sum[OVR_W-1:0];
            end
         end
         OP_FIRE: begin
            if ((dl_ff != '0) && (dl_ff <= ct_ff)) begin
               res_fired_in = 1'b1;
               if (per_ff == '0) begin
                  dl_in = '0;
               end else begin
                  dl_in = rearm_sum[TIME_BITS] ? TMAX : rearm_sum[TIME_BITS-1:0];
               end
            end
         end
         OP_SCHED: begin
            if (when_ff == '0) begin
               dl_in  = '0;
               per_in = '0;
            end else begin
               if (abs_ff) begin
                  dl_in = when_ff;
               end else begin
                  dl_in = rel_sum[TIME_BITS] ? TMAX : rel_sum[TIME_BITS-1:0];
               end
               per_in = every_ff;
            end
         end
         OP_READ: begin
            res_ovr_in = ovr_ff;
            ovr_in     = '0;
         end
         OP_POST: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_fired_in = res_fired_ff;
               rsp_ovr_in   = res_ovr_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_FETCH;
         ct_ff        <= '0;
         dl_ff        <= '0;
         per_ff       <= '0;
         ovr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         ct_ff        <= ct_in;
         dl_ff        <= dl_in;
         per_ff       <= per_in;
         ovr_ff       <= ovr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      abs_ff       <= abs_in;
      when_ff      <= when_in;
      every_ff     <= every_in;
      delta_ff     <= delta_in;
      rem_ff       <= rem_in;
      dq_ff        <= dq_in;
      res_fired_ff <= res_fired_in;
      res_ovr_ff   <= res_ovr_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_ovr_ff   <= rsp_ovr_in;
   end

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the periodic deadline timer. Request transactions
// come first from a directed table, then from a shaped random mix. A
// behavioral timer model predicts each response the table does not pin, and
// each response is compared field by field in arrival order.
// ----------------------------------------------------------------------------

module testbench;
   import pdt_pkg::*;

   localparam int TW          = TIME_BITS_DEF;
   localparam int STALL_LIMIT = 2000;   // cycles with no transaction on either side
   localparam int RANDOM_OPS  = 425;

   // func code 3 has no operation behind it
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam logic [TW-1:0]    TIME_ONES = '1;
   localparam logic [OVR_W-1:0] OVR_MAX   = '1;

   // table rows: pinned rows carry their response, the rest use the model
   localparam bit PIN  = 1'b1;
   localparam bit CALC = 1'b0;

   typedef struct packed {
      logic [FUNC_W-1:0]     func;
      logic [ABSOLUTE_W-1:0] absolute;
      logic [WHEN_W-1:0]     when;
      logic [EVERY_W-1:0]    every;
      logic [DELTA_W-1:0]    delta;
   } timer_op_type;

   typedef struct packed {
      logic [FIRED_W-1:0] fired;
      logic [OVR_W-1:0]   overruns_read;
   } timer_outcome_type;

   typedef struct {
      timer_op_type      op;
      bit                pinned;
      timer_outcome_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   pdt_req_if req_bus ();
   pdt_rsp_if rsp_bus ();

   periodic_deadline_timer_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Timer model: own copy of time, deadline, period and overrun count
   // ---------------------------------------------------------------------
   logic [TW-1:0]    now_t;
   logic [TW-1:0]    due_t;        // zero = disarmed
   logic [TW-1:0]    interval_t;   // zero = one-shot
   logic [OVR_W-1:0] missed_cnt;

   timer_outcome_type timer_outcomes[$];   // responses still owed by the DUT
   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   bit  no_idle        = 1'b0;             // both sides run flat out while set

   function automatic logic [TW-1:0] sat_time_add(logic [TW-1:0] a, logic [TW-1:0] b);
      logic [TW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TW] ? TIME_ONES : s[TW-1:0];
   endfunction

   // Apply one request to the model and return the response it causes.
   function automatic timer_outcome_type timer_apply(timer_op_type op);
      timer_outcome_type res;
      logic [TW-1:0]     misses;
      res = '0;
      case (op.func)
         FUNC_TICK: begin
            now_t = sat_time_add(now_t, TW'(op.delta));
            if (due_t != '0) begin
               // periodic and behind: skip whole missed periods, count them
               if (interval_t != '0 && now_t > due_t) begin
                  misses = (now_t - due_t) / interval_t;
                  due_t  = due_t + misses * interval_t;
                  if (misses >= TW'(OVR_MAX - missed_cnt))
                     missed_cnt = OVR_MAX;
                  else
                     missed_cnt = missed_cnt + misses[OVR_W-1:0];
               end
               // at most one expiry per tick
               if (due_t <= now_t) begin
                  res.fired = 1'b1;
                  due_t = (interval_t == '0) ? '0 : sat_time_add(due_t, interval_t);
               end
            end
         end
         FUNC_SCHED: begin
            if (op.when == '0) begin
               due_t      = '0;
               interval_t = '0;
            end else begin
               due_t      = op.absolute ? op.when : sat_time_add(op.when, now_t);
               interval_t = op.every;
            end
         end
         FUNC_READ: begin
            res.overruns_read = missed_cnt;
            missed_cnt = '0;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic stim_row_type mk_row(logic [FUNC_W-1:0] func, logic abs_flag,
                                           logic [TW-1:0] when_v, logic [TW-1:0] every_v,
                                           logic [DELTA_W-1:0] delta_v, bit pinned,
                                           logic fired_v, logic [OVR_W-1:0] ovr_v);
      stim_row_type r;
      r.op     = '{func: func, absolute: abs_flag, when: when_v, every: every_v,
                   delta: delta_v};
      r.pinned = pinned;
      r.want   = '{fired: fired_v, overruns_read: ovr_v};
      return r;
   endfunction

   // Random request, shaped so that deadlines sit near the current time and
   // periods are small enough to fire and fall behind often. A share of
   // every field stays fully random so all bits toggle.
   function automatic timer_op_type random_timer_op();
      timer_op_type  op;
      int            pick;
      logic [TW-1:0] off;
      op.func     = FUNC_TICK;
      op.absolute = 1'($urandom_range(0, 1));
      op.when     = {16'($urandom()), $urandom()};
      op.every    = {16'($urandom()), $urandom()};
      op.delta    = 16'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         op.func = FUNC_UNUSED;
      end else if (pick < 23) begin
         op.func = FUNC_READ;
      end else if (pick < 45) begin
         op.func = FUNC_SCHED;
         off  = TW'($urandom_range(0, 200000));
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            op.absolute = 1'b0;
            op.when     = off + 1'b1;
         end else if (pick < 55) begin
            op.absolute = 1'b1;
            op.when     = now_t + off;
         end else if (pick < 65) begin
            // deadline already in the past
            op.absolute = 1'b1;
            op.when     = (now_t > off) ? now_t - off : TW'(1);
         end else if (pick < 75) begin
            op.when = '0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 25)
            op.every = '0;
         else if (pick < 70)
            op.every = TW'($urandom_range(1, 70000));
         else if (pick < 80)
            op.every = TW'($urandom_range(1, 16));
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            op.delta = '0;
         else if (pick < 16)
            op.delta = '1;
         else if (pick < 36)
            op.delta = 16'($urandom_range(1, 64));
      end
      return op;
   endfunction

   // ---------------------------------------------------------------------
   // Request side. valid stays high across back-to-back transactions; it
   // only drops for a random gap or a drain.
   // ---------------------------------------------------------------------
   task automatic send_op(timer_op_type op, bit pinned, timer_outcome_type want);
      timer_outcome_type got;
      while (!no_idle && $urandom_range(0, 99) < 29) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.func     <= op.func;
      req_bus.absolute <= op.absolute;
      req_bus.when     <= op.when;
      req_bus.every    <= op.every;
      req_bus.delta    <= op.delta;
      do @(posedge clock); while (!req_bus.ready);
      // accepted at this edge: model state moves in request order
      got = timer_apply(op);
      timer_outcomes.push_back(pinned ? want : got);
   endtask

   // Hold the request side until every owed response has come back.
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (timer_outcomes.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // Response side: random backpressure and in-order checking
   // ---------------------------------------------------------------------
   initial begin
      timer_outcome_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (timer_outcomes.size() == 0) begin
               $error("unexpected response transaction: fired=%0d overruns_read=%0d",
                      rsp_bus.fired, rsp_bus.overruns_read);
               mismatch_count++;
            end else begin
               want = timer_outcomes.pop_front();
               if (rsp_bus.fired !== want.fired) begin
                  $error("fired: expected %0d, actual %0d", want.fired, rsp_bus.fired);
                  mismatch_count++;
               end
               if (rsp_bus.overruns_read !== want.overruns_read) begin
                  $error("overruns_read: expected %0d, actual %0d",
                         want.overruns_read, rsp_bus.overruns_read);
                  mismatch_count++;
               end
            end
         end
         rsp_bus.ready <= !reset && (no_idle || $urandom_range(0, 99) >= 29);
      end
   end

   // Watchdog: ends a run that stops moving transactions.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      stim_row_type      rows[$];
      timer_op_type      op;
      timer_outcome_type none;
      int                counted;

      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.func     <= FUNC_TICK;
      req_bus.absolute <= 1'b0;
      req_bus.when     <= '0;
      req_bus.every    <= '0;
      req_bus.delta    <= '0;
      now_t      = '0;
      due_t      = '0;
      interval_t = '0;
      missed_cnt = '0;
      none       = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Schedules, unused codes, ticks while disarmed and reads
      // known to return zero carry their (all-zero) response; the rest go through the model.
      rows = {
         // reset state
         mk_row(FUNC_READ,   1'b0, 48'd0,     48'd0,     16'd0,      PIN,  1'b0, 32'd0),
         // zero delta on a disarmed timer
         mk_row(FUNC_TICK,   1'b0, 48'd0,     48'd0,     16'd0,      PIN,  1'b0, 32'd0),
         // unused code, every field at its top
         mk_row(FUNC_UNUSED, 1'b1, TIME_ONES, TIME_ONES, 16'hFFFF,   PIN,  1'b0, 32'd0),
         mk_row(FUNC_TICK,   1'b0, 48'd0,     48'd0,     16'hFFFF,   PIN,  1'b0, 32'd0),
         // relative deadline overflows and saturates
         mk_row(FUNC_SCHED,  1'b0, TIME_ONES, 48'd0,     16'd0,      PIN,  1'b0, 32'd0),
         mk_row(FUNC_TICK,   1'b0, 48'd0,     48'd0,     16'd1,      CALC, 1'b0, 32'd0),
         // one-shot deadline already passed: fires on the next tick only
         mk_row(FUNC_SCHED,  1'b1, 48'd1,     48'd0,     16'd0,      PIN,  1'b0, 32'd0),
         mk_row(FUNC_TICK,   1'b0, 48'd0,     48'd0,     16'd0,      CALC, 1'b0, 32'd0),
         mk_row(FUNC_TICK,   1'b0, 48'd0,     48'd0,     16'd5,      CALC, 1'b0, 32'd0),
         // periodic and far behind: missed periods turn into overruns
         mk_row(FUNC_SCHED,  1'b1, 48'd100,   48'd1000,  16'd0,      PIN,  1'b0, 32'd0),
         mk_row(FUNC_TICK,   1'b0, 48'd0,     48'd0,     16'd0,      CALC, 1'b0, 32'd0),
         mk_row(FUNC_READ,   1'b0, 48'd0,     48'd0,     16'd0,      CALC, 1'b0, 32'd0),
         mk_row(FUNC_READ,   1'b0, 48'd0,     48'd0,     16'd0,      PIN,  1'b0, 32'd0),
         // rearm by a full-scale period saturates the deadline
         mk_row(FUNC_SCHED,  1'b0, 48'd10,    TIME_ONES, 16'd0,      PIN,  1'b0, 32'd0),
         mk_row(FUNC_TICK,   1'b0, 48'd0,     48'd0,     16'd10,     CALC, 1'b0, 32'd0),
         mk_row(FUNC_TICK,   1'b0, 48'd0,     48'd0,     16'hFFFF,   CALC, 1'b0, 32'd0),
         // zero deadline disarms and drops the period
         mk_row(FUNC_SCHED,  1'b0, 48'd0,     48'd123,   16'd0,      PIN,  1'b0, 32'd0),
         mk_row(FUNC_TICK,   1'b0, 48'd0,     48'd0,     16'hFFFF,   PIN,  1'b0, 32'd0),
         // alternating bit patterns on the period and delta fields
         mk_row(FUNC_SCHED,  1'b1, 48'h8000_0000_0000, 48'h5555_5555_5555, 16'h5555,
                PIN, 1'b0, 32'd0),
         mk_row(FUNC_SCHED,  1'b1, 48'd0, 48'hAAAA_AAAA_AAAA, 16'hAAAA,
                PIN, 1'b0, 32'd0),
         // period of one, then a full-size tick
         mk_row(FUNC_SCHED,  1'b0, 48'd3,     48'd1,     16'd0,      PIN,  1'b0, 32'd0),
         mk_row(FUNC_TICK,   1'b0, 48'd0,     48'd0,     16'hFFFF,   CALC, 1'b0, 32'd0),
         mk_row(FUNC_READ,   1'b0, 48'd0,     48'd0,     16'd0,      CALC, 1'b0, 32'd0),
         mk_row(FUNC_UNUSED, 1'b0, 48'd0,     48'd0,     16'd0,      PIN,  1'b0, 32'd0),
         mk_row(FUNC_TICK,   1'b0, 48'd0,     48'd0,     16'd0,      CALC, 1'b0, 32'd0)
      };
      foreach (rows[i])
         send_op(rows[i].op, rows[i].pinned, rows[i].want);

      // sender waits for the block to go empty before the random part
      hold_until_drained();

      // Random part.
      counted = 0;
      while (counted < RANDOM_OPS) begin
         no_idle = (counted >= 250 && counted < 330);
         if ($urandom_range(0, 99) == 0)
            hold_until_drained();
         op = random_timer_op();
         send_op(op, CALC, none);
         counted++;
      end
      no_idle = 1'b0;

      // drain, then allow for a full divide worth of trailing activity
      hold_until_drained();
      repeat (64) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
